[rtl/sssd_pkg.sv]
// Package with the item types, mode codes and glyph table of the seven-segment scan driver.
package sssd_pkg;

	localparam int SCAN_PERIOD = 40;
	localparam int COUNT_W = $clog2(SCAN_PERIOD + 1);
	localparam int NUM_DIGITS = 4;
	localparam int DIGIT_W = $clog2(NUM_DIGITS);
	localparam int CODE_W = 6;
	localparam int POINT_W = 3;
	localparam int SEG_W = 7;

	localparam logic [COUNT_W-1:0] DRIVE_D0 = COUNT_W'(1);
	localparam logic [COUNT_W-1:0] DRIVE_D1 = COUNT_W'(10);
	localparam logic [COUNT_W-1:0] DRIVE_D2 = COUNT_W'(20);
	localparam logic [COUNT_W-1:0] DRIVE_D3 = COUNT_W'(30);

	localparam logic [POINT_W-1:0] POINT_NONE = POINT_W'(5);

	localparam logic [CODE_W-1:0] CODE_ZERO = CODE_W'(0);
	localparam logic [CODE_W-1:0] CODE_ONE = CODE_W'(1);
	localparam logic [CODE_W-1:0] CODE_F = CODE_W'(15);
	localparam logic [CODE_W-1:0] CODE_U = CODE_W'(30);
	localparam logic [CODE_W-1:0] CODE_L = CODE_W'(31);
	localparam logic [CODE_W-1:0] CODE_N = CODE_W'(32);
	localparam logic [CODE_W-1:0] CODE_I = CODE_W'(33);

	typedef enum logic [1:0] {
		MODE_TICK     = 2'd0,
		MODE_LOAD     = 2'd1,
		MODE_INVALID  = 2'd2,
		MODE_OVERFLOW = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t                    mode;
		logic [3:0][CODE_W-1:0]   codes;
		logic [POINT_W-1:0]       point;
	} item_t;

	typedef struct packed {
		logic [NUM_DIGITS-1:0] anode;
		logic [SEG_W-1:0]      segments;
		logic                  point;
	} result_t;

	// Bit 7 marks a defined code; bits 6..0 hold the active-low segment pattern.
	function automatic logic [7:0] glyph_lookup(input logic [CODE_W-1:0] code);
		logic [7:0] entry;
		unique case (code)
			6'd0:    entry = 8'hC0;
			6'd1:    entry = 8'hF9;
			6'd2:    entry = 8'hA4;
			6'd3:    entry = 8'hB0;
			6'd4:    entry = 8'h99;
			6'd5:    entry = 8'h92;
			6'd6:    entry = 8'h82;
			6'd7:    entry = 8'hF8;
			6'd8:    entry = 8'h80;
			6'd9:    entry = 8'h90;
			6'd10:   entry = 8'hA0;
			6'd11:   entry = 8'h83;
			6'd12:   entry = 8'hC6;
			6'd13:   entry = 8'hA1;
			6'd14:   entry = 8'h86;
			6'd15:   entry = 8'h8E;
			6'd30:   entry = 8'hE3;
			6'd31:   entry = 8'hC7;
			6'd32:   entry = 8'hAB;
			6'd33:   entry = 8'hA1;
			6'd34:   entry = 8'hBF;
			6'd35:   entry = 8'hFF;
			default: entry = 8'h00;
		endcase
		return entry;
	endfunction

endpackage

[rtl/sssd_state.sv]
// Display state of the seven-segment scan driver and the next result it produces.
module sssd_state (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  sssd_pkg::item_t  item,
	output sssd_pkg::result_t result
);

	logic [sssd_pkg::COUNT_W-1:0]                     count_q;
	logic [3:0][sssd_pkg::CODE_W-1:0]                 glyph_q;
	logic [sssd_pkg::POINT_W-1:0]                     point_store_q;
	logic                                             invalid_q;
	logic                                             overflow_q;
	logic [sssd_pkg::NUM_DIGITS-1:0]                  anode_q;
	logic [sssd_pkg::SEG_W-1:0]                       seg_q;
	logic                                             point_q;

	logic                                             tick;
	logic                                             load_inv;
	logic                                             load_ovf;
	logic [3:0][sssd_pkg::CODE_W-1:0]                 glyph_eff;
	logic [sssd_pkg::POINT_W-1:0]                     point_eff;
	logic                                             drive;
	logic [sssd_pkg::DIGIT_W-1:0]                     digit;
	logic [7:0]                                       entry;
	logic [sssd_pkg::COUNT_W-1:0]                     count_next;

	assign tick = (item.mode == sssd_pkg::MODE_TICK);
	assign load_inv = tick && invalid_q;
	assign load_ovf = tick && !invalid_q && overflow_q;

	always_comb begin
		glyph_eff = glyph_q;
		point_eff = point_store_q;
		if (load_inv) begin
			glyph_eff = {sssd_pkg::CODE_ONE, sssd_pkg::CODE_N, sssd_pkg::CODE_U,
				sssd_pkg::CODE_I};
			point_eff = sssd_pkg::POINT_NONE;
		end else if (load_ovf) begin
			glyph_eff = {sssd_pkg::CODE_ZERO, sssd_pkg::CODE_U, sssd_pkg::CODE_F,
				sssd_pkg::CODE_L};
			point_eff = sssd_pkg::POINT_NONE;
		end
	end

	always_comb begin
		drive = tick;
		digit = '0;
		unique case (count_q)
			sssd_pkg::DRIVE_D0: digit = sssd_pkg::DIGIT_W'(0);
			sssd_pkg::DRIVE_D1: digit = sssd_pkg::DIGIT_W'(1);
			sssd_pkg::DRIVE_D2: digit = sssd_pkg::DIGIT_W'(2);
			sssd_pkg::DRIVE_D3: digit = sssd_pkg::DIGIT_W'(3);
			default:            drive = 1'b0;
		endcase
	end

	assign entry = sssd_pkg::glyph_lookup(glyph_eff[digit]);

	always_comb begin
		if (!drive && count_q >= sssd_pkg::COUNT_W'(sssd_pkg::SCAN_PERIOD)) begin
			count_next = sssd_pkg::COUNT_W'(1);
		end else begin
			count_next = count_q + sssd_pkg::COUNT_W'(1);
		end
	end

	always_comb begin
		result.anode = anode_q;
		result.segments = seg_q;
		result.point = point_q;
		if (drive) begin
			result.anode = sssd_pkg::NUM_DIGITS'(1) << digit;
			result.point = (point_eff != sssd_pkg::POINT_W'(digit));
			if (entry[7]) begin
				result.segments = entry[sssd_pkg::SEG_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			glyph_q <= '0;
			point_store_q <= '0;
			invalid_q <= 1'b0;
			overflow_q <= 1'b0;
			anode_q <= '0;
			seg_q <= '0;
			point_q <= 1'b0;
		end else if (advance) begin
			unique case (item.mode)
				sssd_pkg::MODE_LOAD: begin
					glyph_q <= item.codes;
					point_store_q <= item.point;
				end
				sssd_pkg::MODE_INVALID: begin
					invalid_q <= 1'b1;
				end
				sssd_pkg::MODE_OVERFLOW: begin
					overflow_q <= 1'b1;
				end
				sssd_pkg::MODE_TICK: begin
					glyph_q <= glyph_eff;
					point_store_q <= point_eff;
					if (load_inv) begin
						invalid_q <= 1'b0;
					end
					if (load_ovf) begin
						overflow_q <= 1'b0;
					end
					count_q <= count_next;
					anode_q <= result.anode;
					seg_q <= result.segments;
					point_q <= result.point;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/seven_segment_scan_driver.sv]
// Top level of the seven-segment scan driver: input register, display state and result register.
//
// Each accepted item gives exactly one result item once the output side is ready, and a new item
// can be taken every clock while the output side does not stall. The input register and the
// result register lie on the path; the scan counter, the message load and the glyph table
// lookup all sit in the single logic step between them. A scan tick (tuser 0) advances the counter,
// which drives digits 0 to 3 at counts 1, 10, 20 and 30 of a 40-count refresh cycle; the
// result shows the held anode, segment and point lines after the item is applied.
module seven_segment_scan_driver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// code_digit0[5:0], code_digit1[11:6], code_digit2[17:12], code_digit3[23:18],
	// point_position[26:24], zero fill [31:27]
	input  logic [31:0] s_tdata,
	// mode[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// anode_select[3:0], segment_lines[10:4], point_line[11], zero fill [15:12]
	output logic [15:0] m_tdata
);

	logic               valid_s1;
	sssd_pkg::item_t    item_s1;
	logic               valid_s2;
	sssd_pkg::result_t  result_s2;
	sssd_pkg::result_t  result_next;
	logic               out_free;
	logic               advance;

	assign out_free = !valid_s2 || m_tready;
	assign advance = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.mode <= sssd_pkg::mode_t'(s_tuser);
			item_s1.codes[0] <= s_tdata[5:0];
			item_s1.codes[1] <= s_tdata[11:6];
			item_s1.codes[2] <= s_tdata[17:12];
			item_s1.codes[3] <= s_tdata[23:18];
			item_s1.point <= s_tdata[26:24];
		end
	end

	sssd_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.item   (item_s1),
		.result (result_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_next;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata = {4'b0000, result_s2.point, result_s2.segments, result_s2.anode};

`ifndef SYNTHESIS
	a_anode_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0(m_tdata[3:0]))
		else $error("anode select is not one-hot");

	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> (valid_s1 && $stable(item_s1)))
		else $error("stalled item changed in the input register");

	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !valid_s1) |=> !m_tvalid)
		else $error("result repeated after it was taken");

	a_fill_shows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("advanced item did not reach the output");
`endif

endmodule

[bench/display_line_checker.sv]
// Checker that predicts the seven-segment scan driver outputs and compares every result item.
module display_line_checker
	import sssd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	output int          failures,
	output int          outstanding
);

	localparam logic [CODE_W-1:0] CODE_DASH = CODE_W'(34);
	localparam logic [CODE_W-1:0] CODE_BLANK = CODE_W'(35);

	// Active-low patterns of the hex digits, digit 0 in the lowest seven bits.
	localparam logic [16*SEG_W-1:0] HEX_SEGS = {
		7'h0E, 7'h06, 7'h21, 7'h46, 7'h03, 7'h20, 7'h10, 7'h00,
		7'h78, 7'h02, 7'h12, 7'h19, 7'h30, 7'h24, 7'h79, 7'h40
	};

	int                        scan_count;
	logic [3:0][CODE_W-1:0]    glyph_store;
	logic [POINT_W-1:0]        point_store;
	logic                      invalid_pending;
	logic                      overflow_pending;
	result_t                   shown;
	result_t                   expected_lines[$];

	// Bit 7 says whether the code has a pattern at all.
	function automatic logic [7:0] segment_pattern(input logic [CODE_W-1:0] code);
		if (code < 16) begin
			return {1'b1, HEX_SEGS[code*SEG_W +: SEG_W]};
		end
		case (code)
			CODE_U:     return {1'b1, 7'h63};
			CODE_L:     return {1'b1, 7'h47};
			CODE_N:     return {1'b1, 7'h2B};
			CODE_I:     return {1'b1, 7'h21};
			CODE_DASH:  return {1'b1, 7'h3F};
			CODE_BLANK: return {1'b1, 7'h7F};
			default:    return 8'h00;
		endcase
	endfunction

	task automatic light_digit(input int digit);
		logic [7:0] pattern;
		pattern = segment_pattern(glyph_store[digit]);
		shown.anode = NUM_DIGITS'(1) << digit;
		if (pattern[7]) begin
			shown.segments = pattern[SEG_W-1:0];
		end
		shown.point = (point_store == POINT_W'(digit)) ? 1'b0 : 1'b1;
	endtask

	task automatic advance_display(input mode_t mode, input logic [3:0][CODE_W-1:0] codes,
			input logic [POINT_W-1:0] point);
		case (mode)
			MODE_LOAD: begin
				glyph_store = codes;
				point_store = point;
			end
			MODE_INVALID: begin
				invalid_pending = 1'b1;
			end
			MODE_OVERFLOW: begin
				overflow_pending = 1'b1;
			end
			default: begin
				if (invalid_pending) begin
					glyph_store = {CODE_ONE, CODE_N, CODE_U, CODE_I};
					point_store = POINT_NONE;
					invalid_pending = 1'b0;
				end else if (overflow_pending) begin
					glyph_store = {CODE_ZERO, CODE_U, CODE_F, CODE_L};
					point_store = POINT_NONE;
					overflow_pending = 1'b0;
				end
				if (scan_count == DRIVE_D0) begin
					light_digit(0);
				end else if (scan_count == DRIVE_D1) begin
					light_digit(1);
				end else if (scan_count == DRIVE_D2) begin
					light_digit(2);
				end else if (scan_count == DRIVE_D3) begin
					light_digit(3);
				end else if (scan_count >= SCAN_PERIOD) begin
					scan_count = 0;
				end
				scan_count++;
			end
		endcase
		expected_lines.push_back(shown);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			scan_count = 0;
			glyph_store = '0;
			point_store = '0;
			invalid_pending = 1'b0;
			overflow_pending = 1'b0;
			shown = '0;
			expected_lines.delete();
			failures = 0;
			outstanding = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				advance_display(mode_t'(s_tuser), s_tdata[23:0], s_tdata[26:24]);
			end
			if (m_tvalid && m_tready) begin
				if (expected_lines.size() == 0) begin
					$error("result item with no expectation waiting: %h", m_tdata);
					failures++;
				end else begin
					want = expected_lines.pop_front();
					if (m_tdata[3:0] !== want.anode) begin
						$error("anode_select: expected %h, got %h", want.anode, m_tdata[3:0]);
						failures++;
					end
					if (m_tdata[10:4] !== want.segments) begin
						$error("segment_lines: expected %h, got %h", want.segments,
							m_tdata[10:4]);
						failures++;
					end
					if (m_tdata[11] !== want.point) begin
						$error("point_line: expected %b, got %b", want.point, m_tdata[11]);
						failures++;
					end
				end
			end
			outstanding = expected_lines.size();
		end
	end

endmodule

[bench/seven_segment_scan_driver_tb.sv]
// Testbench top for the seven-segment scan driver: clock, reset, item stimulus and verdict.
module seven_segment_scan_driver_tb;
	import sssd_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = MODE_TICK;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	int          failures;
	int          outstanding;
	bit          steady = 1'b0;

	always #5 clk = ~clk;

	seven_segment_scan_driver u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	display_line_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.failures    (failures),
		.outstanding (outstanding)
	);

	// Mostly no gap, some short ones and a few long ones.
	function automatic int gap_len();
		int r;
		if (steady) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic send_item(input mode_t mode, input logic [3:0][CODE_W-1:0] codes,
			input logic [POINT_W-1:0] point);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {5'b0, point, codes};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	function automatic logic [CODE_W-1:0] random_code();
		if ($urandom_range(0, 99) < 85) begin
			return CODE_W'($urandom_range(0, 35));
		end
		return CODE_W'($urandom_range(36, 63));
	endfunction

	initial begin
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				stall = gap_len();
				m_tready <= (stall == 0);
			end
		end
	end

	initial begin
		int r;
		mode_t mode;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// The first tick after reset drives no digit.
		send_item(MODE_TICK, '0, '0);
		send_item(MODE_LOAD, {6'd15, 6'd0, 6'd34, 6'd35}, 3'd0);
		send_item(MODE_TICK, '0, '0);
		// Codes without a pattern are loaded here; the tick after them drives no digit.
		send_item(MODE_LOAD, {6'd63, 6'd63, 6'd63, 6'd63}, 3'd7);
		send_item(MODE_TICK, '0, '0);
		// Both requests pending: invalid is served first, overflow on the next tick.
		send_item(MODE_OVERFLOW, '0, '0);
		send_item(MODE_INVALID, '0, '0);
		send_item(MODE_TICK, '0, '0);
		send_item(MODE_TICK, '0, '0);
		send_item(MODE_TICK, '0, '0);
		send_item(MODE_LOAD, {6'd0, 6'd36, 6'd29, 6'd16}, 3'd3);
		send_item(MODE_INVALID, '0, '0);
		send_item(MODE_INVALID, '0, '0);
		send_item(MODE_TICK, '0, '0);
		send_item(MODE_LOAD, {6'd42, 6'd21, 6'd9, 6'd31}, 3'd5);
		send_item(MODE_LOAD, {6'd33, 6'd32, 6'd30, 6'd14}, 3'd4);
		send_item(MODE_TICK, '0, '0);
		send_item(MODE_OVERFLOW, '0, '0);
		send_item(MODE_LOAD, {6'd8, 6'd7, 6'd1, 6'd2}, 3'd1);
		send_item(MODE_TICK, '0, '0);
		send_item(MODE_LOAD, {6'd11, 6'd12, 6'd13, 6'd10}, 3'd2);
		send_item(MODE_TICK, '0, '0);

		for (int n = 0; n < 1400; n++) begin
			if ($urandom_range(0, 99) == 0) begin
				steady = !steady;
			end
			r = $urandom_range(0, 99);
			if (r < 72) begin
				mode = MODE_TICK;
			end else if (r < 86) begin
				mode = MODE_LOAD;
			end else if (r < 93) begin
				mode = MODE_INVALID;
			end else begin
				mode = MODE_OVERFLOW;
			end
			send_item(mode, {random_code(), random_code(), random_code(), random_code()},
				POINT_W'($urandom_range(0, 7)));
		end
		s_tvalid <= 1'b0;
		steady = 1'b0;

		while (outstanding != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (failures == 0) begin
			$display("seven_segment_scan_driver_tb: done, clean");
		end else begin
			$display("seven_segment_scan_driver_tb: done, errors");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("seven_segment_scan_driver_tb: done, errors");
		$finish;
	end

endmodule

[filelist.f]
rtl/sssd_pkg.sv
rtl/sssd_state.sv
rtl/seven_segment_scan_driver.sv
bench/display_line_checker.sv
bench/seven_segment_scan_driver_tb.sv
